// ===== hw/rtl/sla_pkg.sv =====
// ============================================================================
// sla_pkg: shared types and constants of the serial line assembler
// Character codes, store sizing and the record passed from the classifier to
// the line engine.
// ============================================================================
`default_nettype none

package sla_pkg;

    // Line store depth and the index width that follows from it
    localparam int LINE_STORE_DEPTH = 64;
    localparam int IDX_W            = $clog2(LINE_STORE_DEPTH);

    // Fixed field widths
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int CAP_W    = 7;
    localparam int M_DATA_W = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

    // Character codes
    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_RETURN  = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'h00;

    // Byte classes decided by the front end
    typedef enum logic [1:0] {
        KIND_DATA,
        KIND_NEWLINE,
        KIND_NUL
    } byte_kind_t;

    typedef struct packed {
        byte_kind_t        kind;
        logic [BYTE_W-1:0] value;
    } rx_req_t;

    function automatic byte_kind_t classify(input logic [BYTE_W-1:0] b);
        byte_kind_t k;
        if (b == CH_NEWLINE) begin
            k = KIND_NEWLINE;
        end else if (b == CH_NUL) begin
            k = KIND_NUL;
        end else begin
            k = KIND_DATA;
        end
        return k;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/serial_line_assembler.sv =====
// ============================================================================
// serial_line_assembler: newline-delimited line framer
// Collect received serial bytes into lines and emit each complete line.
// ============================================================================
// Bytes enter on the s_ stream one request at a time and are classified and
// queued (two entries). The line engine writes ordinary bytes into a 64-entry
// line store; a newline ends the line, a trailing carriage return is
// stripped, and a non-empty line shorter than output_capacity is sent on the
// m_ stream one byte per request, with m_tlast on the final byte and the line
// length beside every byte. Empty lines and lines of output_capacity or more
// bytes give nothing. A NUL byte, or a 64th byte of a line, starts discard
// mode: bytes are dropped until the next newline, which emits nothing.
// Flow: an ordinary byte or a newline that emits nothing is taken while the
// engine is idle and leaves it free for the next request; a newline that
// emits a line drains it, each byte taking a store read state and an output
// load state. The queue absorbs two requests during a drain, after which
// s_tready drops until the engine is free again. The store needs no clearing
// pass after reset. Write output_capacity only while idle.
// ============================================================================
`default_nettype none

module serial_line_assembler (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration
    input  wire logic                          cfg_we,
    input  wire logic [sla_pkg::CAP_W-1:0]     cfg_wdata,  // output_capacity
    // receive stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sla_pkg::BYTE_W-1:0]    s_tdata,    // [7:0] rx_byte
    // line stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sla_pkg::M_DATA_W-1:0]       m_tdata,    // [7:0] line_byte,
                                                           // [13:8] line_length,
                                                           // [15:14] zero
    output logic                               m_tlast     // last_of_line
);

    sla_pkg::rx_req_t q_wdata;
    sla_pkg::rx_req_t q_rdata;
    logic             q_full;
    logic             q_push;
    logic             q_pop;
    logic             q_valid;

    // Classify incoming bytes; hold off the sender while the queue is full
    sla_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_wdata  (q_wdata)
    );

    // Buffer classified requests so either side can stall on its own
    sla_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .wdata   (q_wdata),
        .full    (q_full),
        .pop     (q_pop),
        .rvalid  (q_valid),
        .rdata   (q_rdata)
    );

    // Store, frame and drain lines
    sla_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .q_valid   (q_valid),
        .q_rdata   (q_rdata),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/sla_front.sv =====
// ============================================================================
// sla_front: receive-side classifier
// Accept a byte when the request queue has room and tag it by class.
// ============================================================================
`default_nettype none

module sla_front (
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [sla_pkg::BYTE_W-1:0]    s_tdata,   // [7:0] rx_byte
    input  wire logic                          q_full,
    output logic                               q_push,
    output sla_pkg::rx_req_t                   q_wdata
);

    assign s_tready      = ~q_full;
    assign q_push        = s_tvalid & ~q_full;
    assign q_wdata.kind  = sla_pkg::classify(s_tdata);
    assign q_wdata.value = s_tdata;

endmodule

`default_nettype wire

// ===== hw/rtl/sla_queue.sv =====
// ============================================================================
// sla_queue: two-entry request queue
// Decouple the classifier from the line engine.
// ============================================================================
`default_nettype none

module sla_queue (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire sla_pkg::rx_req_t wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  rvalid,
    output sla_pkg::rx_req_t      rdata
);

    sla_pkg::rx_req_t entry_reg [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == 2'd2);
    assign rvalid  = (count_reg != 2'd0);
    assign rdata   = entry_reg[rd_ptr_reg];
    assign do_push = push & ~full;
    assign do_pop  = pop & rvalid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (aresetn) begin
            assert (!(push && full))
                else $error("sla_queue: push while full");
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/sla_back.sv =====
// ============================================================================
// sla_back: line engine
// Store line bytes, frame on newline and drain a finished line to the output.
// ============================================================================
`default_nettype none

module sla_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_we,
    input  wire logic [sla_pkg::CAP_W-1:0]     cfg_wdata,
    input  wire logic                          q_valid,
    input  wire sla_pkg::rx_req_t              q_rdata,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [sla_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_LOAD
    } state_t;

    localparam int IDX_W = sla_pkg::IDX_W;

    state_t                         state_reg, state_next;
    logic [IDX_W-1:0]               fill_reg, fill_next;
    logic                           drop_reg, drop_next;
    logic [sla_pkg::BYTE_W-1:0]     last_byte_reg, last_byte_next;
    logic [IDX_W-1:0]               len_reg, len_next;
    logic [IDX_W-1:0]               rd_idx_reg, rd_idx_next;
    logic [sla_pkg::CAP_W-1:0]      cap_reg, cap_next;
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [sla_pkg::M_DATA_W-1:0]   m_tdata_reg, m_tdata_next;
    logic                           m_tlast_reg, m_tlast_next;

    logic [sla_pkg::BYTE_W-1:0]     store_mem [sla_pkg::LINE_STORE_DEPTH];
    logic [sla_pkg::BYTE_W-1:0]     rd_data_reg;
    logic                           mem_we;
    logic                           mem_re;
    logic [IDX_W-1:0]               strip_len;
    logic                           out_free;
    logic                           is_last;

    assign out_free = ~m_tvalid_reg | m_tready;
    assign is_last  = (rd_idx_reg == len_reg - IDX_W'(1));
    assign q_pop    = (state_reg == ST_IDLE) & q_valid;
    assign mem_re   = (state_reg == ST_READ);
    assign strip_len = ((fill_reg != '0) && (last_byte_reg == sla_pkg::CH_RETURN))
                       ? fill_reg - IDX_W'(1) : fill_reg;

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        drop_next      = drop_reg;
        last_byte_next = last_byte_reg;
        len_next       = len_reg;
        rd_idx_next    = rd_idx_reg;
        cap_next       = cfg_we ? cfg_wdata : cap_reg;
        m_tvalid_next  = m_tvalid_reg & ~m_tready;
        m_tdata_next   = m_tdata_reg;
        m_tlast_next   = m_tlast_reg;
        mem_we         = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (q_rdata.kind == sla_pkg::KIND_NEWLINE) begin
                        fill_next = '0;
                        drop_next = 1'b0;
                        if (!drop_reg && (strip_len != '0) &&
                            (sla_pkg::CAP_W'(strip_len) < cap_reg)) begin
                            len_next    = strip_len;
                            rd_idx_next = '0;
                            state_next  = ST_READ;
                        end
                    end else if (!drop_reg) begin
                        if ((q_rdata.kind == sla_pkg::KIND_NUL) ||
                            (fill_reg >= IDX_W'(sla_pkg::LINE_STORE_DEPTH - 1))) begin
                            drop_next = 1'b1;
                            fill_next = '0;
                        end else begin
                            mem_we         = 1'b1;
                            fill_next      = fill_reg + IDX_W'(1);
                            last_byte_next = q_rdata.value;
                        end
                    end
                end
            end
            ST_READ: begin
                state_next = ST_LOAD;
            end
            ST_LOAD: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(sla_pkg::M_DATA_W - sla_pkg::LEN_W
                                       - sla_pkg::BYTE_W){1'b0}},
                                     sla_pkg::LEN_W'(len_reg), rd_data_reg};
                    m_tlast_next  = is_last;
                    rd_idx_next   = rd_idx_reg + IDX_W'(1);
                    state_next    = is_last ? ST_IDLE : ST_READ;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            drop_reg      <= 1'b0;
            cap_reg       <= sla_pkg::CAP_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            drop_reg      <= drop_next;
            cap_reg       <= cap_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
        last_byte_reg <= last_byte_next;
        len_reg       <= len_next;
        rd_idx_reg    <= rd_idx_next;
        m_tdata_reg   <= m_tdata_next;
        m_tlast_reg   <= m_tlast_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[fill_reg] <= q_rdata.value;
        end
        if (mem_re) begin
            rd_data_reg <= store_mem[rd_idx_reg];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    // Discard mode keeps the store empty
    assert property (@(posedge aclk) disable iff (!aresetn)
        drop_reg |-> (fill_reg == '0))
        else $error("sla_back: store not empty while discarding");

    // A drained line never reads past its own length
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> ((len_reg != '0) && (rd_idx_reg < len_reg)))
        else $error("sla_back: drain index out of line");

    // Requests are taken only while no line is draining
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (state_reg == ST_IDLE))
        else $error("sla_back: request taken during drain");

    // The final byte of a line returns the engine to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && out_free && is_last) |=> (state_reg == ST_IDLE))
        else $error("sla_back: engine did not finish line");

endmodule

`default_nettype wire
